[rtl/hmqb_pkg.sv]
`default_nettype none
package hmqb_pkg;

    localparam int HEIGHT_W   = 17;
    localparam int Z_W        = 19;
    localparam int X2_W       = 13;
    localparam int Y2_W       = 14;
    localparam int NRM_W      = 16;
    localparam int GW_W       = 12;
    localparam int GH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic [GW_W-1:0] GRID_WIDTH_RESET  = 12'd1600;
    localparam logic [GH_W-1:0] GRID_HEIGHT_RESET = 13'd1600;

    localparam logic [HEIGHT_W-1:0] HEIGHT_ONE = 17'd65536;
    localparam logic [Z_W-1:0]      Z_ONES     = '1;
    localparam int                  Z_STEP     = 4096;
    localparam int                  NORMAL_ONE = 16384;

    // normal datapath widths
    localparam int VEC_W     = 25;
    localparam int MAG_W     = 24;
    localparam int ACC_W     = 50;
    localparam int ROOT_IN_W = 54;
    localparam int ROOT_W    = 27;
    localparam int NUM_W     = 50;
    localparam int Q_W       = 24;
    localparam int UNIT_SHIFT  = 30;
    localparam int FINAL_SHIFT = 14;
    localparam int LEN_SHIFT   = 16;

    localparam int QUEUE_DEPTH = 2;

    // vertex order TL, TR, BL, TR, BR, BL; bit v of each mask
    localparam logic [5:0] VTX_DCOL = 6'b011010;
    localparam logic [5:0] VTX_DROW = 6'b110100;
    localparam logic [2:0] LAST_VERTEX = 3'd5;

    typedef struct packed {
        logic [Z_W-1:0]         ha;
        logic [Z_W-1:0]         hb;
        logic [Z_W-1:0]         hc;
        logic [Z_W-1:0]         hd;
        logic signed [X2_W-1:0] x2;
        logic signed [Y2_W-1:0] y2;
        logic [Z_W-1:0]         lo;
        logic [Z_W-1:0]         hi;
        logic                   last_grid;
    } job_t;

endpackage
`default_nettype wire

[rtl/hmqb_channels.sv]
`default_nettype none
interface hmqb_sample_if import hmqb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] height_sample;

    modport source (output valid, output height_sample, input ready);
    modport sink (input valid, input height_sample, output ready);
endinterface

interface hmqb_vertex_if import hmqb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [X2_W-1:0]  vertex_x2;
    logic signed [Y2_W-1:0]  vertex_y2;
    logic [Z_W-1:0]          vertex_z;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic [Z_W-1:0]          low_height;
    logic [Z_W-1:0]          high_height;
    logic                    last_of_quad;
    logic                    last_of_grid;

    modport source (output valid, output vertex_x2, output vertex_y2, output vertex_z,
                    output normal_x, output normal_y, output normal_z,
                    output low_height, output high_height,
                    output last_of_quad, output last_of_grid, input ready);
    modport sink (input valid, input vertex_x2, input vertex_y2, input vertex_z,
                  input normal_x, input normal_y, input normal_z,
                  input low_height, input high_height,
                  input last_of_quad, input last_of_grid, output ready);
endinterface
`default_nettype wire

[rtl/hmqb_front.sv]
`default_nettype none
module hmqb_front import hmqb_pkg::*; #(
    parameter int MAX_WIDTH         = 2048,
    parameter int MAX_HEIGHT        = 4096,
    parameter int CURVE_TABLE_DEPTH = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            restart,
    input  wire logic [GW_W-1:0] grid_w,
    input  wire logic [GH_W-1:0] grid_h,
    hmqb_sample_if.sink          samples,
    output logic                 job_valid,
    input  wire logic            job_ready,
    output job_t                 job
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int IDX_W = $clog2(CURVE_TABLE_DEPTH + 1);
    localparam int POS_W = HEIGHT_W + IDX_W;

    typedef enum logic [2:0] {
        F_IDLE   = 3'b001,
        F_CURVE  = 3'b010,
        F_COMMIT = 3'b100
    } front_state_t;

    function automatic logic [Z_W-1:0] curve_entry(input logic [63:0] idx);
        logic [63:0] q;
        logic [63:0] v;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] m;
        logic [63:0] e;
        q  = (idx << 40) / CURVE_TABLE_DEPTH;
        v  = q << 20;
        lo = 64'd0;
        hi = 64'd4096;
        for (int s = 0; s < 13; s++)
        begin
            if (lo < hi)
            begin
                m = (lo + hi + 64'd1) >> 1;
                if (m * m * m * m * m <= v)
                    lo = m;
                else
                    hi = m - 64'd1;
            end
        end
        e = (64'd80 * idx * lo + 64'(CURVE_TABLE_DEPTH / 2)) / CURVE_TABLE_DEPTH;
        return e[Z_W-1:0];
    endfunction

    logic [Z_W-1:0] curve_rom [0:CURVE_TABLE_DEPTH];
    logic [Z_W-1:0] line_mem  [0:MAX_WIDTH-1];

    for (genvar g = 0; g <= CURVE_TABLE_DEPTH; g++)
    begin : g_curve
        assign curve_rom[g] = curve_entry(64'(g));
    end

    front_state_t   state_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [Z_W-1:0] left_reg;
    logic [Z_W-1:0] ul_reg;
    logic [Z_W-1:0] min_reg;
    logic [Z_W-1:0] max_reg;
    logic [Z_W-1:0] z_reg;
    logic [Z_W-1:0] above_reg;
    logic [Z_W-1:0] rom0_reg;
    logic [Z_W-1:0] rom1_reg;
    logic [15:0]    f_reg;

    logic [HEIGHT_W-1:0] h_clamp;
    logic [POS_W-1:0]    pos;
    logic [IDX_W-1:0]    idx0;
    logic [IDX_W-1:0]    idx1;
    logic                accept;
    logic [Z_W-1:0]      diff;
    logic [Z_W+15:0]     prod;
    logic [Z_W+16:0]     rnd;
    logic [Z_W-1:0]      z_next;
    logic                quad;
    logic                grid_start;
    logic [Z_W-1:0]      base_min;
    logic [Z_W-1:0]      base_max;
    logic [Z_W-1:0]      min_next;
    logic [Z_W-1:0]      max_next;
    logic                commit;
    logic                col_wrap;
    logic                row_wrap;

    assign samples.ready = (state_reg == F_IDLE);
    assign accept = samples.valid && samples.ready;

    always_comb
    begin
        h_clamp = (samples.height_sample > HEIGHT_ONE) ? HEIGHT_ONE : samples.height_sample;
        pos  = POS_W'(h_clamp) * POS_W'(CURVE_TABLE_DEPTH);
        idx0 = pos[15+IDX_W:16];
        idx1 = (idx0 == IDX_W'(CURVE_TABLE_DEPTH)) ? idx0 : idx0 + 1'b1;
    end

    always_comb
    begin
        diff   = rom1_reg - rom0_reg;
        prod   = (Z_W+16)'(diff) * (Z_W+16)'(f_reg);
        rnd    = {1'b0, prod} + (Z_W+17)'(32768);
        z_next = rom0_reg + rnd[Z_W+15:16];
    end

    always_comb
    begin
        quad       = (row_reg != '0) && (col_reg != '0);
        grid_start = (row_reg == '0) && (col_reg == '0);
        base_min   = grid_start ? Z_ONES : min_reg;
        base_max   = grid_start ? '0 : max_reg;
        min_next   = base_min;
        max_next   = base_max;
        if (quad)
        begin
            if (ul_reg < min_next) min_next = ul_reg;
            if (above_reg < min_next) min_next = above_reg;
            if (left_reg < min_next) min_next = left_reg;
            if (z_reg < min_next) min_next = z_reg;
            if (ul_reg > max_next) max_next = ul_reg;
            if (above_reg > max_next) max_next = above_reg;
            if (left_reg > max_next) max_next = left_reg;
            if (z_reg > max_next) max_next = z_reg;
        end
        col_wrap = (int'(col_reg) + 1 >= int'(grid_w));
        row_wrap = (int'(row_reg) + 1 >= int'(grid_h));
        commit   = (state_reg == F_COMMIT) && (!quad || job_ready);
    end

    assign job_valid     = (state_reg == F_COMMIT) && quad;
    assign job.ha        = ul_reg;
    assign job.hb        = above_reg;
    assign job.hc        = left_reg;
    assign job.hd        = z_reg;
    assign job.x2        = X2_W'(2 * int'(col_reg) - 2 - int'(grid_w));
    assign job.y2        = Y2_W'(2 * int'(row_reg) - 2 - int'(grid_h));
    assign job.lo        = min_next;
    assign job.hi        = max_next;
    assign job.last_grid = (int'(row_reg) == int'(grid_h) - 1)
                           && (int'(col_reg) == int'(grid_w) - 1);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rom0_reg  <= curve_rom[idx0];
            rom1_reg  <= curve_rom[idx1];
            f_reg     <= pos[15:0];
            above_reg <= line_mem[col_reg];
        end
        if (commit)
            line_mem[col_reg] <= z_reg;
        if (state_reg == F_CURVE)
            z_reg <= z_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            left_reg  <= '0;
            ul_reg    <= '0;
            min_reg   <= Z_ONES;
            max_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                        state_reg <= F_CURVE;
                end
                F_CURVE:
                begin
                    state_reg <= F_COMMIT;
                end
                F_COMMIT:
                begin
                    if (commit)
                    begin
                        state_reg <= F_IDLE;
                        ul_reg    <= above_reg;
                        left_reg  <= z_reg;
                        min_reg   <= min_next;
                        max_reg   <= max_next;
                        if (col_wrap)
                        begin
                            col_reg <= '0;
                            row_reg <= row_wrap ? '0 : row_reg + 1'b1;
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
                min_reg <= Z_ONES;
                max_reg <= '0;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/hmqb_queue.sv]
`default_nettype none
module hmqb_queue import hmqb_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  job_t      push_job,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

[rtl/hmqb_back.sv]
`default_nettype none
module hmqb_back import hmqb_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    output logic      job_ready,
    input  job_t      job,
    hmqb_vertex_if.source vertices
);

    typedef enum logic [4:0] {
        B_IDLE   = 5'b00001,
        B_SQUARE = 5'b00010,
        B_ROOT   = 5'b00100,
        B_DIVIDE = 5'b01000,
        B_EMIT   = 5'b10000
    } back_state_t;

    localparam logic [1:0] PASS_N1    = 2'd0;
    localparam logic [1:0] PASS_N2    = 2'd1;
    localparam logic [1:0] PASS_FINAL = 2'd2;
    localparam logic [4:0] ROOT_LAST  = 5'(ROOT_W - 1);
    localparam logic [4:0] DIV_LAST   = 5'(Q_W);

    back_state_t state_reg;
    job_t        job_reg;
    logic [1:0]  pass_reg;
    logic [1:0]  k_reg;
    logic [4:0]  it_reg;
    logic [2:0]  v_reg;
    logic signed [VEC_W-1:0] vec_reg [0:2];
    logic signed [VEC_W-1:0] u1_reg  [0:2];
    logic signed [VEC_W-1:0] res_reg [0:2];
    logic signed [NRM_W-1:0] nq_reg  [0:2];
    logic [ACC_W-1:0]     acc_reg;
    logic [ROOT_IN_W-1:0] rv_reg;
    logic [ROOT_IN_W-1:0] rr_reg;
    logic [ROOT_IN_W-1:0] rb_reg;
    logic [ROOT_W-1:0]    len_reg;
    logic [ROOT_W-1:0]    rem_reg;
    logic [Q_W-1:0]       nlow_reg;
    logic [Q_W-1:0]       quo_reg;
    logic                 neg_reg;

    logic                    out_valid_reg;
    logic signed [X2_W-1:0]  x2_reg;
    logic signed [Y2_W-1:0]  y2_reg;
    logic [Z_W-1:0]          z_reg;
    logic signed [NRM_W-1:0] nx_reg;
    logic signed [NRM_W-1:0] ny_reg;
    logic signed [NRM_W-1:0] nz_reg;
    logic [Z_W-1:0]          lo_reg;
    logic [Z_W-1:0]          hi_reg;
    logic                    lq_reg;
    logic                    lg_reg;

    logic signed [VEC_W-1:0] cur;
    logic [MAG_W-1:0]        mag;
    logic [2*MAG_W-1:0]      mag_sq;
    logic [ACC_W-1:0]        acc_sum;
    logic [ROOT_IN_W-1:0]    rt;
    logic                    rge;
    logic [ROOT_IN_W-1:0]    rr_next;
    logic [NUM_W-1:0]        num;
    logic [ROOT_W:0]         t2;
    logic                    dge;
    logic [ROOT_W:0]         t2_sub;
    logic [Q_W-1:0]          q_fin;
    logic signed [VEC_W-1:0] q_signed;
    logic [NRM_W-1:0]        q_clamp;
    logic signed [VEC_W-1:0] res_now [0:2];
    logic                    emit_load;
    logic                    dcol;
    logic                    drow;

    assign job_ready = (state_reg == B_IDLE);

    always_comb
    begin
        cur     = vec_reg[k_reg];
        mag     = cur[VEC_W-1] ? MAG_W'(-cur) : MAG_W'(cur);
        mag_sq  = mag * mag;
        acc_sum = acc_reg + ACC_W'(mag_sq);

        rt      = rr_reg + rb_reg;
        rge     = (rv_reg >= rt);
        rr_next = rge ? ((rr_reg >> 1) + rb_reg) : (rr_reg >> 1);

        if (pass_reg == PASS_FINAL)
            num = (NUM_W'(mag) << FINAL_SHIFT) + NUM_W'(len_reg >> 1);
        else
            num = (NUM_W'(mag) << UNIT_SHIFT) + NUM_W'(len_reg >> 1);

        t2     = {rem_reg, nlow_reg[Q_W-1]};
        dge    = (t2 >= {1'b0, len_reg});
        t2_sub = t2 - {1'b0, len_reg};
        q_fin  = {quo_reg[Q_W-2:0], dge};
        q_signed = neg_reg ? -$signed(VEC_W'(q_fin)) : $signed(VEC_W'(q_fin));
        q_clamp  = (q_fin > Q_W'(NORMAL_ONE)) ? NRM_W'(NORMAL_ONE) : NRM_W'(q_fin);

        for (int i = 0; i < 3; i++)
            res_now[i] = (2'(i) == k_reg) ? q_signed : res_reg[i];

        emit_load = (state_reg == B_EMIT) && (!out_valid_reg || vertices.ready);
        dcol      = VTX_DCOL[v_reg];
        drow      = VTX_DROW[v_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            pass_reg      <= PASS_N1;
            k_reg         <= '0;
            it_reg        <= '0;
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        pass_reg  <= PASS_N1;
                        k_reg     <= '0;
                        state_reg <= B_SQUARE;
                    end
                end
                B_SQUARE:
                begin
                    if (k_reg == 2'd2)
                    begin
                        it_reg    <= '0;
                        state_reg <= B_ROOT;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                B_ROOT:
                begin
                    if (it_reg == ROOT_LAST)
                    begin
                        k_reg     <= '0;
                        it_reg    <= '0;
                        state_reg <= B_DIVIDE;
                    end
                    else
                    begin
                        it_reg <= it_reg + 1'b1;
                    end
                end
                B_DIVIDE:
                begin
                    if (it_reg == DIV_LAST)
                    begin
                        it_reg <= '0;
                        if (k_reg != 2'd2)
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                        else
                        begin
                            k_reg <= '0;
                            if (pass_reg == PASS_FINAL)
                            begin
                                v_reg     <= '0;
                                state_reg <= B_EMIT;
                            end
                            else
                            begin
                                pass_reg  <= pass_reg + 1'b1;
                                state_reg <= B_SQUARE;
                            end
                        end
                    end
                    else
                    begin
                        it_reg <= it_reg + 1'b1;
                    end
                end
                B_EMIT:
                begin
                    if (emit_load)
                    begin
                        v_reg <= v_reg + 1'b1;
                        if (v_reg == LAST_VERTEX)
                            state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (vertices.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                job_reg    <= job;
                acc_reg    <= '0;
                vec_reg[0] <= $signed(VEC_W'(job.ha)) - $signed(VEC_W'(job.hb));
                vec_reg[1] <= $signed(VEC_W'(job.ha)) - $signed(VEC_W'(job.hc));
                vec_reg[2] <= $signed(VEC_W'(Z_STEP));
            end
            B_SQUARE:
            begin
                acc_reg <= acc_sum;
                if (k_reg == 2'd2)
                begin
                    if (pass_reg == PASS_FINAL)
                        rv_reg <= ROOT_IN_W'(acc_sum);
                    else
                        rv_reg <= ROOT_IN_W'(acc_sum) << LEN_SHIFT;
                    rr_reg <= '0;
                    rb_reg <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
                end
            end
            B_ROOT:
            begin
                if (rge)
                    rv_reg <= rv_reg - rt;
                rr_reg <= rr_next;
                rb_reg <= rb_reg >> 2;
                if (it_reg == ROOT_LAST)
                    len_reg <= rr_next[ROOT_W-1:0];
            end
            B_DIVIDE:
            begin
                if (it_reg == '0)
                begin
                    rem_reg  <= ROOT_W'(num[NUM_W-1:Q_W]);
                    nlow_reg <= num[Q_W-1:0];
                    quo_reg  <= '0;
                    neg_reg  <= cur[VEC_W-1];
                end
                else
                begin
                    rem_reg  <= dge ? t2_sub[ROOT_W-1:0] : t2[ROOT_W-1:0];
                    nlow_reg <= nlow_reg << 1;
                    quo_reg  <= q_fin;
                    if (it_reg == DIV_LAST)
                    begin
                        res_reg[k_reg] <= q_signed;
                        nq_reg[k_reg]  <= neg_reg ? -$signed(q_clamp) : $signed(q_clamp);
                        if (k_reg == 2'd2)
                        begin
                            acc_reg <= '0;
                            if (pass_reg == PASS_N1)
                            begin
                                for (int i = 0; i < 3; i++)
                                    u1_reg[i] <= res_now[i];
                                vec_reg[0] <= $signed(VEC_W'(job_reg.hc))
                                              - $signed(VEC_W'(job_reg.hd));
                                vec_reg[1] <= $signed(VEC_W'(job_reg.hb))
                                              - $signed(VEC_W'(job_reg.hd));
                                vec_reg[2] <= $signed(VEC_W'(Z_STEP));
                            end
                            else if (pass_reg == PASS_N2)
                            begin
                                for (int i = 0; i < 3; i++)
                                    vec_reg[i] <= u1_reg[i] + res_now[i];
                            end
                        end
                    end
                end
            end
            B_EMIT:
            begin
                if (emit_load)
                begin
                    x2_reg <= job_reg.x2 + (dcol ? X2_W'(2) : X2_W'(0));
                    y2_reg <= job_reg.y2 + (drow ? Y2_W'(2) : Y2_W'(0));
                    z_reg  <= drow ? (dcol ? job_reg.hd : job_reg.hc)
                                   : (dcol ? job_reg.hb : job_reg.ha);
                    nx_reg <= nq_reg[0];
                    ny_reg <= nq_reg[1];
                    nz_reg <= nq_reg[2];
                    lo_reg <= job_reg.lo;
                    hi_reg <= job_reg.hi;
                    lq_reg <= (v_reg == LAST_VERTEX);
                    lg_reg <= (v_reg == LAST_VERTEX) && job_reg.last_grid;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign vertices.valid        = out_valid_reg;
    assign vertices.vertex_x2    = x2_reg;
    assign vertices.vertex_y2    = y2_reg;
    assign vertices.vertex_z     = z_reg;
    assign vertices.normal_x     = nx_reg;
    assign vertices.normal_y     = ny_reg;
    assign vertices.normal_z     = nz_reg;
    assign vertices.low_height   = lo_reg;
    assign vertices.high_height  = hi_reg;
    assign vertices.last_of_quad = lq_reg;
    assign vertices.last_of_grid = lg_reg;

endmodule
`default_nettype wire

[rtl/heightmap_quad_mesh_builder.sv]
// The front takes one sample at a time. An interior sample occupies the normal unit for 3
// passes of square, root and 3 divides, then 6 vertices, all on the shared iterative square
// root and divider. Front and normal unit overlap through a 2-entry queue.
// Reset: counters zero, min all ones, max zero, sizes 1600; line store not cleared.
`default_nettype none
module heightmap_quad_mesh_builder import hmqb_pkg::*; #(
    parameter int MAX_WIDTH         = 2048,
    parameter int MAX_HEIGHT        = 4096,
    parameter int CURVE_TABLE_DEPTH = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    hmqb_sample_if.sink                samples,
    hmqb_vertex_if.source              vertices
);

    logic [GW_W-1:0] grid_width_reg;
    logic [GH_W-1:0] grid_height_reg;
    logic [GW_W-1:0] grid_w;
    logic [GH_W-1:0] grid_h;

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GW_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[GH_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        if (grid_width_reg < GW_W'(2))
            grid_w = GW_W'(2);
        else if (int'(grid_width_reg) > MAX_WIDTH)
            grid_w = GW_W'(MAX_WIDTH);
        else
            grid_w = grid_width_reg;
        if (grid_height_reg < GH_W'(2))
            grid_h = GH_W'(2);
        else if (int'(grid_height_reg) > MAX_HEIGHT)
            grid_h = GH_W'(MAX_HEIGHT);
        else
            grid_h = grid_height_reg;
    end

    hmqb_front #(
        .MAX_WIDTH         (MAX_WIDTH),
        .MAX_HEIGHT        (MAX_HEIGHT),
        .CURVE_TABLE_DEPTH (CURVE_TABLE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (cfg_write),
        .grid_w    (grid_w),
        .grid_h    (grid_h),
        .samples   (samples),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job)
    );

    hmqb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    hmqb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .vertices  (vertices)
    );

    a_normal_z_positive: assert property (@(posedge clk) disable iff (!rst_n)
        vertices.valid |-> !vertices.normal_z[NRM_W-1])
        else $error("quad normal points downward");

    a_min_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        vertices.valid |-> vertices.low_height <= vertices.high_height)
        else $error("running minimum above running maximum");

    a_grid_end_on_quad_end: assert property (@(posedge clk) disable iff (!rst_n)
        vertices.valid && vertices.last_of_grid |-> vertices.last_of_quad)
        else $error("grid end flagged inside a quad");

    a_one_sample_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> !samples.ready)
        else $error("front took a second sample while busy");

endmodule
`default_nettype wire

[dv/hmqb_mesh_checker.sv]
`default_nettype none
module hmqb_mesh_checker import hmqb_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    hmqb_sample_if                     samples,
    hmqb_vertex_if                     vertices,
    output int                         failures,
    output int                         pending
);

    localparam int LUT_DEPTH = 1024;
    localparam int LINE_DEPTH = 2048;
    localparam int ROW_LIMIT = 4096;

    typedef struct {
        logic signed [X2_W-1:0]  x2;
        logic signed [Y2_W-1:0]  y2;
        logic [Z_W-1:0]          z;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic [Z_W-1:0]          lo;
        logic [Z_W-1:0]          hi;
        logic                    quad_end;
        logic                    grid_end;
    } mesh_vertex_t;

    mesh_vertex_t      vertex_q[$];
    longint unsigned   curve_lut[0:LUT_DEPTH];
    logic [Z_W-1:0]    line_heights[0:LINE_DEPTH-1];
    logic [Z_W-1:0]    left_z;
    logic [Z_W-1:0]    upper_left_z;
    int unsigned       col_cnt;
    int unsigned       row_cnt;
    logic [Z_W-1:0]    min_z;
    logic [Z_W-1:0]    max_z;
    logic [GW_W-1:0]   grid_w;
    logic [GH_W-1:0]   grid_h;

    function automatic longint unsigned root5(longint unsigned v);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned m;
        lo = 0;
        hi = 4096;
        while (lo < hi)
        begin
            m = (lo + hi + 1) / 2;
            if (m * m * m * m * m <= v)
                lo = m;
            else
                hi = m - 1;
        end
        return lo;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint rounded_ratio(longint v, longint unsigned mul,
                                             longint unsigned den);
        longint unsigned m;
        longint q;
        m = (v < 0) ? -v : v;
        q = longint'((m * mul + den / 2) / den);
        return (v < 0) ? -q : q;
    endfunction

    function automatic logic [Z_W-1:0] curve_height(logic [HEIGHT_W-1:0] h);
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned frac;
        longint unsigned z;
        pos = longint'(h) * LUT_DEPTH;
        idx = pos >> 16;
        frac = pos & 64'hFFFF;
        if (idx >= LUT_DEPTH)
            z = curve_lut[LUT_DEPTH];
        else
            z = curve_lut[idx]
                + (((curve_lut[idx + 1] - curve_lut[idx]) * frac + 32768) >> 16);
        return z[Z_W-1:0];
    endfunction

    task automatic unit_q22(input longint n0, input longint n1, input longint n2,
                            output longint u0, output longint u1, output longint u2);
        longint unsigned sq;
        longint unsigned len;
        sq = longint'(n0 * n0) + longint'(n1 * n1) + longint'(n2 * n2);
        len = int_sqrt(sq << 16);
        u0 = rounded_ratio(n0, 64'd1 << 30, len);
        u1 = rounded_ratio(n1, 64'd1 << 30, len);
        u2 = rounded_ratio(n2, 64'd1 << 30, len);
    endtask

    function automatic longint clamp_normal(longint v);
        if (v > NORMAL_ONE)
            return NORMAL_ONE;
        if (v < -NORMAL_ONE)
            return -NORMAL_ONE;
        return v;
    endfunction

    task automatic restart_grid();
        col_cnt = 0;
        row_cnt = 0;
        min_z = Z_ONES;
        max_z = '0;
    endtask

    task automatic predict_quad(input logic [HEIGHT_W-1:0] sample);
        int unsigned  w;
        int unsigned  hg;
        int unsigned  col;
        int unsigned  row;
        logic [HEIGHT_W-1:0] h;
        logic [Z_W-1:0] z;
        logic [Z_W-1:0] above;
        logic [Z_W-1:0] hv[4];
        longint a, b, c, d;
        longint p0, p1, p2, q0, q1, q2, s0, s1, s2;
        longint unsigned len;
        mesh_vertex_t vtx;
        int dc;
        int dr;
        w = (grid_w < 2) ? 2 : ((grid_w > LINE_DEPTH) ? LINE_DEPTH : grid_w);
        hg = (grid_h < 2) ? 2 : ((grid_h > ROW_LIMIT) ? ROW_LIMIT : grid_h);
        h = (sample > HEIGHT_ONE) ? HEIGHT_ONE : sample;
        z = curve_height(h);
        col = col_cnt;
        row = row_cnt;
        if (col >= w)
            col = 0;
        if (row >= hg)
            row = 0;
        if (row == 0 && col == 0)
        begin
            min_z = Z_ONES;
            max_z = '0;
        end
        above = line_heights[col];
        if (row >= 1 && col >= 1)
        begin
            hv[0] = upper_left_z;
            hv[1] = above;
            hv[2] = left_z;
            hv[3] = z;
            for (int k = 0; k < 4; k++)
            begin
                if (hv[k] < min_z)
                    min_z = hv[k];
                if (hv[k] > max_z)
                    max_z = hv[k];
            end
            a = hv[0];
            b = hv[1];
            c = hv[2];
            d = hv[3];
            unit_q22(a - b, a - c, Z_STEP, p0, p1, p2);
            unit_q22(c - d, b - d, Z_STEP, q0, q1, q2);
            s0 = p0 + q0;
            s1 = p1 + q1;
            s2 = p2 + q2;
            len = int_sqrt(longint'(s0 * s0) + longint'(s1 * s1) + longint'(s2 * s2));
            vtx.nx = NRM_W'(clamp_normal(rounded_ratio(s0, NORMAL_ONE, len)));
            vtx.ny = NRM_W'(clamp_normal(rounded_ratio(s1, NORMAL_ONE, len)));
            vtx.nz = NRM_W'(clamp_normal(rounded_ratio(s2, NORMAL_ONE, len)));
            vtx.lo = min_z;
            vtx.hi = max_z;
            for (int v = 0; v < 6; v++)
            begin
                dc = VTX_DCOL[v];
                dr = VTX_DROW[v];
                vtx.x2 = X2_W'(2 * (int'(col) - 1 + dc) - int'(w));
                vtx.y2 = Y2_W'(2 * (int'(row) - 1 + dr) - int'(hg));
                vtx.z = hv[2 * dr + dc];
                vtx.quad_end = (v == LAST_VERTEX);
                vtx.grid_end = (v == LAST_VERTEX) && row == hg - 1 && col == w - 1;
                vertex_q.push_back(vtx);
            end
        end
        upper_left_z = above;
        line_heights[col] = z;
        left_z = z;
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= hg)
                row = 0;
        end
        col_cnt = col;
        row_cnt = row;
    endtask

    task automatic report(string field, longint got, longint want);
        $display("mismatch on %s at %0t: got %0d, want %0d", field, $realtime, got, want);
        failures++;
    endtask

    task automatic check_field(string field, longint got, longint want);
        if (got != want)
            report(field, got, want);
    endtask

    initial
    begin
        longint unsigned q;
        failures = 0;
        pending = 0;
        for (int i = 0; i <= LUT_DEPTH; i++)
        begin
            q = (longint'(i) << 40) / LUT_DEPTH;
            curve_lut[i] = (80 * longint'(i) * root5(q << 20) + LUT_DEPTH / 2) / LUT_DEPTH;
        end
        for (int i = 0; i < LINE_DEPTH; i++)
            line_heights[i] = '0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        mesh_vertex_t want;
        if (!rst_n)
        begin
            left_z = '0;
            upper_left_z = '0;
            grid_w = GRID_WIDTH_RESET;
            grid_h = GRID_HEIGHT_RESET;
            restart_grid();
            vertex_q.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_GRID_WIDTH)
                    grid_w = cfg_data[GW_W-1:0];
                else
                    grid_h = cfg_data[GH_W-1:0];
                restart_grid();
            end
            if (samples.valid && samples.ready)
                predict_quad(samples.height_sample);
            if (vertices.valid && vertices.ready)
            begin
                if (vertex_q.size() == 0)
                    report("unexpected vertex", 1, 0);
                else
                begin
                    want = vertex_q.pop_front();
                    check_field("vertex_x2", vertices.vertex_x2, want.x2);
                    check_field("vertex_y2", vertices.vertex_y2, want.y2);
                    check_field("vertex_z", vertices.vertex_z, want.z);
                    check_field("normal_x", vertices.normal_x, want.nx);
                    check_field("normal_y", vertices.normal_y, want.ny);
                    check_field("normal_z", vertices.normal_z, want.nz);
                    check_field("low_height", vertices.low_height, want.lo);
                    check_field("high_height", vertices.high_height, want.hi);
                    check_field("last_of_quad", vertices.last_of_quad, want.quad_end);
                    check_field("last_of_grid", vertices.last_of_grid, want.grid_end);
                end
            end
        end
        pending = vertex_q.size();
    end

endmodule
`default_nettype wire

[dv/heightmap_quad_mesh_builder_tb.sv]
`default_nettype none
module heightmap_quad_mesh_builder_tb import hmqb_pkg::*;;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    failures;
    int                    pending;
    bit                    calm;
    bit                    hold_kick;

    hmqb_sample_if sample_ch ();
    hmqb_vertex_if vertex_ch ();

    heightmap_quad_mesh_builder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .samples  (sample_ch),
        .vertices (vertex_ch)
    );

    hmqb_mesh_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .samples  (sample_ch),
        .vertices (vertex_ch),
        .failures (failures),
        .pending  (pending)
    );

    initial
        clk = 1'b0;

    always
        #10 clk = ~clk;

    initial
    begin
        #40000000;
        $display("FAILURE");
        $finish;
    end

    // hold ready low for a long stretch when kicked, else random back-pressure
    initial
    begin
        int hold_left;
        hold_left = 0;
        vertex_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_kick)
            begin
                hold_kick = 1'b0;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                vertex_ch.ready <= 1'b0;
            end
            else
                vertex_ch.ready <= calm || ($urandom_range(0, 99) >= 8);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_request(input logic [HEIGHT_W-1:0] h);
        while (!calm && $urandom_range(0, 99) < 8)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.height_sample <= h;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    function automatic logic [HEIGHT_W-1:0] random_height();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return HEIGHT_ONE;
            2: return HEIGHT_W'($urandom_range(65537, 131071));
            default: return HEIGHT_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(random_height());
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic set_grid(input int w, input int h);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_GRID_WIDTH;
        cfg_data = '0;
        calm = 1'b0;
        hold_kick = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.height_sample = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default sizes: first row only, no quads
        send_random(40);
        drain();

        set_grid(2, 2);
        send_request(17'd0);
        send_request(HEIGHT_ONE);
        send_request(HEIGHT_ONE);
        send_request(17'd0);
        send_request(17'h1FFFF);
        send_request(17'd65537);
        send_request(17'd1);
        send_request(17'd32768);
        drain();

        // sizes below the minimum clamp to two
        set_grid(0, 1);
        send_request(17'd65535);
        send_request(17'd32768);
        send_request(17'd16384);
        send_request(17'd100);
        send_random(4);
        drain();

        // widest row, clamped from the largest register value; first row only
        set_grid(13'h1FFF, 3);
        send_random(20);
        drain();

        calm = 1'b1;
        set_grid(3, 13'h1FFF);
        send_random(30);
        drain();
        calm = 1'b0;

        set_grid(7, 4);
        send_random(20);
        hold_kick = 1'b1;
        send_random(100);
        drain();

        set_grid(4, 5);
        send_random(60);
        drain();
        write_reg(REG_GRID_HEIGHT, 5);
        send_random(40);
        drain();

        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
